[src/integer_alu_evaluator_core_assert.svh]
// Assertion macros for the integer ALU evaluator.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef INTEGER_ALU_EVALUATOR_CORE_ASSERT_SVH
`define INTEGER_ALU_EVALUATOR_CORE_ASSERT_SVH

// Checked only out of reset.
`define IAE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define IAE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/iae_pkg.sv]
// Shared types and constants of the integer ALU evaluator.
// No dependencies.
package iae_pkg;

  localparam int XLEN    = 64;                 // port width of operands and result
  localparam int DATA_W  = 64;                 // arithmetic width, 8..64
  localparam int SH_W    = $clog2(DATA_W);
  localparam int LO_W    = DATA_W / 2;
  localparam int HI_W    = DATA_W - LO_W;

  typedef logic [DATA_W-1:0] word_t;

  typedef enum logic [4:0] {
    CMD_ADD  = 5'd0,  CMD_SUB  = 5'd1,  CMD_MUL  = 5'd2,  CMD_DIV  = 5'd3,
    CMD_MOD  = 5'd4,  CMD_AND  = 5'd5,  CMD_OR   = 5'd6,  CMD_XOR  = 5'd7,
    CMD_SHL  = 5'd8,  CMD_SHR  = 5'd9,  CMD_EQ   = 5'd10, CMD_NE   = 5'd11,
    CMD_LT   = 5'd12, CMD_GT   = 5'd13, CMD_LE   = 5'd14, CMD_GE   = 5'd15,
    CMD_LAND = 5'd16, CMD_LOR  = 5'd17, CMD_NEG  = 5'd18, CMD_LNOT = 5'd19,
    CMD_BNOT = 5'd20
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_DIV0  = 2'd1,
    ERR_SHIFT = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    SEL_SIMPLE = 2'd0,
    SEL_MUL    = 2'd1,
    SEL_DIV    = 2'd2,
    SEL_MOD    = 2'd3
  } sel_t;

  // Control that travels with each transaction down the pipeline.
  typedef struct packed {
    logic  valid;
    sel_t  sel;
    word_t simple;
    err_t  err;
    logic  neg_q;
    logic  neg_r;
  } ctl_t;

endpackage

[src/iae_front.sv]
// Decode stage: operand cut, the operations other than multiply and divide, divider setup.
// Depends on iae_pkg.
module iae_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_fire,
  input  logic [4:0]            in_command,
  input  logic [iae_pkg::XLEN-1:0] in_operand_a,
  input  logic [iae_pkg::XLEN-1:0] in_operand_b,
  output iae_pkg::ctl_t         ctl_r,
  output iae_pkg::word_t        op_a_r,
  output iae_pkg::word_t        op_b_r,
  output iae_pkg::word_t        mag_a_r,
  output iae_pkg::word_t        mag_b_r
);
  import iae_pkg::*;

  word_t a, b;
  logic  sh_bad;
  logic  [SH_W-1:0] sh;
  ctl_t  ctl_nxt;

  assign a      = in_operand_a[DATA_W-1:0];
  assign b      = in_operand_b[DATA_W-1:0];
  assign sh     = b[SH_W-1:0];
  assign sh_bad = b[DATA_W-1] || (b >= word_t'(DATA_W));

  always_comb begin
    ctl_nxt        = '0;
    ctl_nxt.valid  = in_fire;
    ctl_nxt.sel    = SEL_SIMPLE;
    ctl_nxt.err    = ERR_NONE;
    ctl_nxt.neg_q  = a[DATA_W-1] ^ b[DATA_W-1];
    ctl_nxt.neg_r  = a[DATA_W-1];
    case (in_command)
      CMD_ADD:  ctl_nxt.simple = a + b;
      CMD_SUB:  ctl_nxt.simple = a - b;
      CMD_MUL:  ctl_nxt.sel    = SEL_MUL;
      CMD_DIV, CMD_MOD: begin
        if (b == '0) begin
          ctl_nxt.err = ERR_DIV0;
        end else begin
          ctl_nxt.sel = (in_command == CMD_DIV) ? SEL_DIV : SEL_MOD;
        end
      end
      CMD_AND:  ctl_nxt.simple = a & b;
      CMD_OR:   ctl_nxt.simple = a | b;
      CMD_XOR:  ctl_nxt.simple = a ^ b;
      CMD_SHL, CMD_SHR: begin
        if (sh_bad) begin
          ctl_nxt.err = ERR_SHIFT;
        end else if (in_command == CMD_SHL) begin
          ctl_nxt.simple = a << sh;
        end else begin
          ctl_nxt.simple = word_t'($signed(a) >>> sh);
        end
      end
      CMD_EQ:   ctl_nxt.simple = word_t'(a == b);
      CMD_NE:   ctl_nxt.simple = word_t'(a != b);
      CMD_LT:   ctl_nxt.simple = word_t'($signed(a) < $signed(b));
      CMD_GT:   ctl_nxt.simple = word_t'($signed(a) > $signed(b));
      CMD_LE:   ctl_nxt.simple = word_t'($signed(a) <= $signed(b));
      CMD_GE:   ctl_nxt.simple = word_t'($signed(a) >= $signed(b));
      CMD_LAND: ctl_nxt.simple = word_t'((a != '0) && (b != '0));
      CMD_LOR:  ctl_nxt.simple = word_t'((a != '0) || (b != '0));
      CMD_NEG:  ctl_nxt.simple = '0 - a;
      CMD_LNOT: ctl_nxt.simple = word_t'(a == '0);
      CMD_BNOT: ctl_nxt.simple = ~a;
      default:  ctl_nxt.simple = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_a_r  <= a;
      op_b_r  <= b;
      mag_a_r <= a[DATA_W-1] ? ('0 - a) : a;
      mag_b_r <= b[DATA_W-1] ? ('0 - b) : b;
    end
  end

endmodule

[src/iae_mul.sv]
// Two-stage wrapping multiplier built from half-width partial products.
// Depends on iae_pkg.
module iae_mul (
  input  logic           clk,
  input  logic           en,
  input  iae_pkg::word_t op_a,
  input  iae_pkg::word_t op_b,
  output iae_pkg::word_t prod_r
);
  import iae_pkg::*;

  logic [DATA_W-1:0] ll_r;
  logic [HI_W-1:0]   lh_r, hl_r;
  logic [DATA_W-1:0] ll_nxt, lh_full, hl_full;

  assign ll_nxt  = DATA_W'(op_a[LO_W-1:0] * op_b[LO_W-1:0]);
  assign lh_full = DATA_W'(op_a[LO_W-1:0] * op_b[DATA_W-1:LO_W]);
  assign hl_full = DATA_W'(op_a[DATA_W-1:LO_W] * op_b[LO_W-1:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r   <= ll_nxt;
      lh_r   <= lh_full[HI_W-1:0];
      hl_r   <= hl_full[HI_W-1:0];
      // only the low word survives; high cross product drops out
      prod_r <= ll_r + {lh_r + hl_r, {LO_W{1'b0}}};
    end
  end

endmodule

[src/iae_div_stage.sv]
// One restoring-division step: one quotient bit per stage.
// Depends on iae_pkg.
module iae_div_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  iae_pkg::ctl_t  ctl_in,
  input  iae_pkg::word_t rem_in,
  input  iae_pkg::word_t quo_in,
  input  iae_pkg::word_t dvs_in,
  output iae_pkg::ctl_t  ctl_r,
  output iae_pkg::word_t rem_r,
  output iae_pkg::word_t quo_r,
  output iae_pkg::word_t dvs_r
);
  import iae_pkg::*;

  word_t shifted, rem_nxt, quo_nxt;
  logic  take;

  // remainder stays below the divisor magnitude, so the shift never overflows
  assign shifted = {rem_in[DATA_W-2:0], quo_in[DATA_W-1]};
  assign take    = (shifted >= dvs_in);
  assign rem_nxt = take ? (shifted - dvs_in) : shifted;
  assign quo_nxt = {quo_in[DATA_W-2:0], take};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      dvs_r <= dvs_in;
    end
  end

endmodule

[src/integer_alu_evaluator_core.sv]
// Channel | Ports                                              | Accepted when
// --------+----------------------------------------------------+------------------------
// input   | in_valid, in_ready, in_command, in_operand_a/b     | in_valid && in_ready
// result  | out_valid, out_ready, out_result, out_error        | out_valid && out_ready
//
// One transaction per cycle while the output is not stalled; the result passes the
// front register, the DATA_W one-bit-per-stage divider stages and the output register.
// All stages advance together; a stalled output holds the whole pipeline.
// Synchronous reset clears valid bits only; no clearing pass.
// Top level of the integer ALU evaluator; depends on iae_pkg, iae_front,
// iae_mul, iae_div_stage and integer_alu_evaluator_core_assert.svh.
`include "integer_alu_evaluator_core_assert.svh"
module integer_alu_evaluator_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [4:0]               in_command,
  input  logic [iae_pkg::XLEN-1:0] in_operand_a,
  input  logic [iae_pkg::XLEN-1:0] in_operand_b,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [iae_pkg::XLEN-1:0] out_result,
  output logic [1:0]               out_error
);
  import iae_pkg::*;

  logic  en;
  ctl_t  ctl_s [0:DATA_W];
  word_t rem_s [0:DATA_W];
  word_t quo_s [0:DATA_W];
  word_t dvs_s [0:DATA_W];
  word_t op_a0, op_b0, mag_a0, mag_b0;
  word_t prod;
  word_t mul_dly_r [0:DATA_W-3];
  word_t res_nxt;
  logic  out_valid_r;
  logic  [XLEN-1:0] out_result_r;
  err_t  out_error_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  iae_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_fire      (in_valid && in_ready),
    .in_command   (in_command),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .ctl_r        (ctl_s[0]),
    .op_a_r       (op_a0),
    .op_b_r       (op_b0),
    .mag_a_r      (mag_a0),
    .mag_b_r      (mag_b0)
  );

  assign rem_s[0] = '0;
  assign quo_s[0] = mag_a0;
  assign dvs_s[0] = mag_b0;

  for (genvar i = 0; i < DATA_W; i++) begin : g_div
    iae_div_stage u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_in (ctl_s[i]),
      .rem_in (rem_s[i]),
      .quo_in (quo_s[i]),
      .dvs_in (dvs_s[i]),
      .ctl_r  (ctl_s[i+1]),
      .rem_r  (rem_s[i+1]),
      .quo_r  (quo_s[i+1]),
      .dvs_r  (dvs_s[i+1])
    );
  end

  iae_mul u_mul (
    .clk    (clk),
    .en     (en),
    .op_a   (op_a0),
    .op_b   (op_b0),
    .prod_r (prod)
  );

  // align the product with the end of the divider lane
  always_ff @(posedge clk) begin
    if (en) begin
      mul_dly_r[0] <= prod;
      for (int k = 1; k < DATA_W - 2; k++) begin
        mul_dly_r[k] <= mul_dly_r[k-1];
      end
    end
  end

  always_comb begin
    case (ctl_s[DATA_W].sel)
      SEL_SIMPLE: res_nxt = ctl_s[DATA_W].simple;
      SEL_MUL:    res_nxt = mul_dly_r[DATA_W-3];
      SEL_DIV:    res_nxt = ctl_s[DATA_W].neg_q ? ('0 - quo_s[DATA_W]) : quo_s[DATA_W];
      SEL_MOD:    res_nxt = ctl_s[DATA_W].neg_r ? ('0 - rem_s[DATA_W]) : rem_s[DATA_W];
      default:    res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_s[DATA_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_result_r <= XLEN'($signed(res_nxt));
      out_error_r  <= ctl_s[DATA_W].err;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_error  = out_error_r;

  `IAE_ASSERT(a_err_zero, out_valid_r && (out_error_r != ERR_NONE) |-> out_result_r == '0, "error result not zero")
  `IAE_ASSERT(a_err_code, out_valid_r |-> (out_error_r == ERR_NONE) || (out_error_r == ERR_DIV0) || (out_error_r == ERR_SHIFT), "bad error code")
  `IAE_ASSERT(a_stall_hold, !en |=> $stable(out_valid_r) && $stable(out_result_r), "output moved during stall")
  `IAE_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_valid_r && !ctl_s[0].valid, "valid set after reset")

endmodule
